>>> rtl/lrupr_pkg.sv
package lrupr_pkg;

  localparam int FRAMES = 4;
  localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_W = FIDX_W;
  localparam int PAGE_W = 16;
  localparam int NUSE_W = 3;
  localparam int CNT_W  = 32;
  localparam int NUSE_RESET = (FRAMES < 4) ? FRAMES : 4;

  typedef logic [FIDX_W-1:0] fidx_t;
  typedef logic [RANK_W-1:0] rank_t;
  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [NUSE_W-1:0] nuse_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic ld;    // capture request, restart scan
    logic scan;  // examine one frame
    logic upd;   // commit frame state and counters, emit word
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
  } dp_status_t;

endpackage

>>> rtl/lru_page_replacement.sv
// LRU page replacement, one page reference per command.
// Result strobe (done) is registered from the update state; start is taken only in idle.
// A new reference is not taken while busy. The scan checks one frame
//   a cycle through a single page comparator, then the update state commits the result.
// Reset (rst, synchronous): all frames empty, ranks and hit/miss counters zero, frames in use = 4.
// done is a one-cycle strobe; the receiver cannot stall it.
module lru_page_replacement (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [lrupr_pkg::PAGE_W-1:0]   page,
  input  logic                           final_ref,
  input  logic                           frames_in_use_we,
  input  logic [lrupr_pkg::NUSE_W-1:0]   frames_in_use,
  output logic                           done,
  output logic                           hit,
  output logic [1:0]                     frame_index,
  output logic                           evicted_valid,
  output logic [lrupr_pkg::PAGE_W-1:0]   evicted_page,
  output logic [lrupr_pkg::CNT_W-1:0]    hit_total,
  output logic [lrupr_pkg::CNT_W-1:0]    miss_total
);

  lrupr_pkg::ctrl_cmd_t  cmd;
  lrupr_pkg::dp_status_t status;

  lrupr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  lrupr_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .page             (page),
    .final_ref        (final_ref),
    .frames_in_use_we (frames_in_use_we),
    .frames_in_use    (frames_in_use),
    .done             (done),
    .hit              (hit),
    .frame_index      (frame_index),
    .evicted_valid    (evicted_valid),
    .evicted_page     (evicted_page),
    .hit_total        (hit_total),
    .miss_total       (miss_total)
  );

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    done |-> !(hit && evicted_valid))
    else $error("hit word reports an eviction");

  a_evict_page_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !evicted_valid) |-> evicted_page == '0)
    else $error("evicted page nonzero without eviction");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("back-to-back result strobes");

endmodule

>>> rtl/lrupr_ctrl.sv
module lrupr_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  lrupr_pkg::dp_status_t  status,
  output lrupr_pkg::ctrl_cmd_t   cmd,
  output logic                   busy
);

  lrupr_pkg::state_t state;
  lrupr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrupr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lrupr_pkg::ST_IDLE: begin
        if (start) begin
          state_next = lrupr_pkg::ST_SCAN;
        end
      end
      lrupr_pkg::ST_SCAN: begin
        if (status.scan_last) begin
          state_next = lrupr_pkg::ST_UPDATE;
        end
      end
      lrupr_pkg::ST_UPDATE: begin
        state_next = lrupr_pkg::ST_IDLE;
      end
      default: begin
        state_next = lrupr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      lrupr_pkg::ST_IDLE: begin
        busy   = 1'b0;
        cmd.ld = start;
      end
      lrupr_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      lrupr_pkg::ST_UPDATE: begin
        cmd.upd = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  a_upd_after_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.upd |-> $past(cmd.scan))
    else $error("update without a preceding scan");

  a_scan_follows_ld: assert property (@(posedge clk) disable iff (rst)
    cmd.ld |=> cmd.scan)
    else $error("scan did not start after accept");

  a_no_start_mid_item: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan || cmd.upd) |-> !cmd.ld)
    else $error("accept during an item");

endmodule

>>> rtl/lrupr_datapath.sv
module lrupr_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  lrupr_pkg::ctrl_cmd_t           cmd,
  output lrupr_pkg::dp_status_t          status,
  input  logic [lrupr_pkg::PAGE_W-1:0]   page,
  input  logic                           final_ref,
  input  logic                           frames_in_use_we,
  input  logic [lrupr_pkg::NUSE_W-1:0]   frames_in_use,
  output logic                           done,
  output logic                           hit,
  output logic [1:0]                     frame_index,
  output logic                           evicted_valid,
  output logic [lrupr_pkg::PAGE_W-1:0]   evicted_page,
  output logic [lrupr_pkg::CNT_W-1:0]    hit_total,
  output logic [lrupr_pkg::CNT_W-1:0]    miss_total
);

  // frame state
  lrupr_pkg::page_t frame_pages  [lrupr_pkg::FRAMES];
  logic             frame_valid  [lrupr_pkg::FRAMES];
  lrupr_pkg::rank_t recency_rank [lrupr_pkg::FRAMES];
  lrupr_pkg::cnt_t  hit_counter;
  lrupr_pkg::cnt_t  miss_counter;
  lrupr_pkg::nuse_t nuse;

  // request and scan results
  lrupr_pkg::page_t req_page;
  logic             req_final;
  lrupr_pkg::fidx_t idx;
  logic             match_found;
  lrupr_pkg::fidx_t match_idx;
  lrupr_pkg::rank_t match_rank;
  logic             empty_found;
  lrupr_pkg::fidx_t empty_idx;
  lrupr_pkg::fidx_t best_idx;
  lrupr_pkg::rank_t best_rank;
  lrupr_pkg::page_t best_page;

  // frame under the scan pointer
  lrupr_pkg::page_t cur_page;
  logic             cur_valid;
  lrupr_pkg::rank_t cur_rank;

  // update decision
  logic             do_fill;
  logic             do_evict;
  lrupr_pkg::fidx_t tgt;
  lrupr_pkg::rank_t old_rank;
  lrupr_pkg::cnt_t  hit_counter_next;
  lrupr_pkg::cnt_t  miss_counter_next;

  assign cur_page  = frame_pages[idx];
  assign cur_valid = frame_valid[idx];
  assign cur_rank  = recency_rank[idx];

  assign status.scan_last = (int'(idx) == int'(nuse) - 1);

  assign do_fill  = !match_found && empty_found;
  assign do_evict = !match_found && !empty_found;
  assign old_rank = match_found ? match_rank : best_rank;

  always_comb begin
    priority if (match_found) begin
      tgt = match_idx;
    end else if (empty_found) begin
      tgt = empty_idx;
    end else begin
      tgt = best_idx;
    end
  end

  assign hit_counter_next  = hit_counter + lrupr_pkg::CNT_W'(match_found);
  assign miss_counter_next = miss_counter + lrupr_pkg::CNT_W'(!match_found);

  // configuration register, clamped to 1..FRAMES
  always_ff @(posedge clk) begin
    if (rst) begin
      nuse <= lrupr_pkg::NUSE_W'(lrupr_pkg::NUSE_RESET);
    end else if (frames_in_use_we) begin
      priority if (frames_in_use == '0) begin
        nuse <= lrupr_pkg::NUSE_W'(1);
      end else if (int'(frames_in_use) > lrupr_pkg::FRAMES) begin
        nuse <= lrupr_pkg::NUSE_W'(lrupr_pkg::FRAMES);
      end else begin
        nuse <= frames_in_use;
      end
    end
  end

  // scan: one frame per cycle
  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      req_page    <= page;
      req_final   <= final_ref;
      idx         <= '0;
      match_found <= 1'b0;
      empty_found <= 1'b0;
    end else if (cmd.scan) begin
      idx <= idx + lrupr_pkg::FIDX_W'(1);
      if (!match_found && cur_valid && cur_page == req_page) begin
        match_found <= 1'b1;
        match_idx   <= idx;
        match_rank  <= cur_rank;
      end
      if (!empty_found && !cur_valid) begin
        empty_found <= 1'b1;
        empty_idx   <= idx;
      end
      // strict compare keeps the lowest frame among equal ranks
      if (idx == '0 || cur_rank > best_rank) begin
        best_idx  <= idx;
        best_rank <= cur_rank;
        best_page <= cur_page;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd && !match_found) begin
      frame_pages[tgt] <= req_page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lrupr_pkg::FRAMES; i++) begin
        frame_valid[i]  <= 1'b0;
        recency_rank[i] <= '0;
      end
    end else if (cmd.upd) begin
      for (int i = 0; i < lrupr_pkg::FRAMES; i++) begin
        if (lrupr_pkg::FIDX_W'(i) == tgt) begin
          recency_rank[i] <= '0;
          frame_valid[i]  <= 1'b1;
        end else if (frame_valid[i] && (do_fill || recency_rank[i] < old_rank)) begin
          recency_rank[i] <= recency_rank[i] + lrupr_pkg::RANK_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_counter  <= '0;
      miss_counter <= '0;
      done         <= 1'b0;
    end else begin
      done <= cmd.upd;
      if (cmd.upd) begin
        hit_counter  <= req_final ? '0 : hit_counter_next;
        miss_counter <= req_final ? '0 : miss_counter_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      hit           <= match_found;
      frame_index   <= 2'(tgt);
      evicted_valid <= do_evict;
      evicted_page  <= do_evict ? best_page : '0;
      hit_total     <= hit_counter_next;
      miss_total    <= miss_counter_next;
    end
  end

  a_nuse_range: assert property (@(posedge clk) disable iff (rst)
    nuse != '0 && int'(nuse) <= lrupr_pkg::FRAMES)
    else $error("frames in use out of range");

  a_upd_after_last: assert property (@(posedge clk) disable iff (rst)
    cmd.upd |-> $past(status.scan_last))
    else $error("update before the scan reached the last frame");

  a_counters_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd.upd && req_final) |=> (hit_counter == '0 && miss_counter == '0))
    else $error("totals not cleared after final word");

endmodule
